// ===== rtl/core/itaf_pkg.sv =====
// Package for the integer to ASCII formatter: payload structs, mode codes,
// sequencer states, character constants and the digit-to-character function.
// No dependencies.
`timescale 1ns / 1ps

package itaf_pkg;

  typedef enum logic [1:0] {
    MODE_DEC = 2'd0,
    MODE_BIN = 2'd1,
    MODE_HEX = 2'd2,
    MODE_USD = 2'd3
  } mode_t;

  typedef struct packed {
    logic signed [31:0] value;
    mode_t              mode;
  } item_t;

  typedef struct packed {
    logic [6:0] text_char;
    logic       last_char;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV,
    S_LOAD,
    S_SIGN,
    S_LEAD,
    S_PFX,
    S_SKIP,
    S_DIGIT,
    S_DOT
  } state_t;

  localparam int MAG_W     = 32;
  localparam int BCD_DIGS  = 10;
  localparam int BCD_W     = 4 * BCD_DIGS;
  localparam int CNT_W     = 6;

  localparam logic [CNT_W-1:0] NDIG_DEC  = CNT_W'(BCD_DIGS);
  localparam logic [CNT_W-1:0] NDIG_HEX  = CNT_W'(MAG_W / 4);
  localparam logic [CNT_W-1:0] NDIG_BIN  = CNT_W'(MAG_W);
  // dollar text keeps at least one unit digit and two cent digits
  localparam logic [CNT_W-1:0] KEEP_USD  = CNT_W'(3);
  localparam logic [CNT_W-1:0] KEEP_STD  = CNT_W'(1);

  localparam logic [6:0] CH_ZERO   = 7'h30;
  localparam logic [6:0] CH_LOWA   = 7'h61;
  localparam logic [6:0] CH_MINUS  = 7'h2d;
  localparam logic [6:0] CH_B      = 7'h62;
  localparam logic [6:0] CH_X      = 7'h78;
  localparam logic [6:0] CH_DOLLAR = 7'h24;
  localparam logic [6:0] CH_DOT    = 7'h2e;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] r;
    if (d <= 4'd9) begin
      r = CH_ZERO + {3'b000, d};
    end else begin
      r = CH_LOWA + {3'b000, d} - 7'd10;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/itaf_bcd_conv.sv =====
// Shift-and-add-3 binary to BCD converter, one input bit per step.
// Depends on itaf_pkg for widths.
`timescale 1ns / 1ps

module itaf_bcd_conv (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic [itaf_pkg::MAG_W-1:0]    bin_in,
  output logic [itaf_pkg::BCD_W-1:0]    bcd
);

  logic [itaf_pkg::MAG_W-1:0] bin;
  logic [itaf_pkg::BCD_W-1:0] adj;

  // each decade is corrected independently before the shift
  always_comb begin
    for (int i = 0; i < itaf_pkg::BCD_DIGS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bin <= bin_in;
      bcd <= '0;
    end else if (step) begin
      bin <= {bin[itaf_pkg::MAG_W-2:0], 1'b0};
      bcd <= {adj[itaf_pkg::BCD_W-2:0], bin[itaf_pkg::MAG_W-1]};
    end
  end

endmodule

// ===== rtl/core/integer_to_ascii_formatter_top.sv =====
// Integer to ASCII formatter: sequencer, digit shift register and output stage.
// Depends on itaf_pkg and itaf_bcd_conv.
//
//   port     dir  type      handshake
//   item     in   item_t    transfer when start & !busy
//   result   out  result_t  transfer on each cycle strobe is high
//
// Binary and hex pass through load, lead and prefix states, then skip leading zero
// digits before the characters. Dollars and decimal first run the BCD pass, one
// input bit per cycle through the shared add-3 unit; decimal's lead state sends nothing.
// Negative dollars take longest. busy is high from the transfer until the last
// character has been sent. Reset is synchronous and returns the sequencer to idle.
// Results are shown for a single cycle; the receiver cannot stall them.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  itaf_pkg::item_t   item,
  output logic              busy,
  output logic              strobe,
  output itaf_pkg::result_t result
);

  itaf_pkg::state_t state, state_next;

  itaf_pkg::mode_t                  mode;
  logic                             neg;
  logic [itaf_pkg::MAG_W-1:0]       mag;
  logic [itaf_pkg::BCD_W-1:0]       digits;
  logic [itaf_pkg::CNT_W-1:0]       ndig;
  logic [4:0]                       cnt;
  logic [itaf_pkg::BCD_W-1:0]       bcd;

  logic                             accept;
  logic                             is_bin;
  logic [3:0]                       top_dig;
  logic [itaf_pkg::CNT_W-1:0]       keep;
  logic [itaf_pkg::MAG_W-1:0]       raw;
  logic                             emit;
  logic [6:0]                       emit_char;
  logic                             emit_last;

  assign accept  = start && !busy;
  assign busy    = (state != itaf_pkg::S_IDLE);
  assign is_bin  = (mode == itaf_pkg::MODE_BIN);
  assign top_dig = is_bin ? {3'b000, digits[itaf_pkg::BCD_W-1]}
                          : digits[itaf_pkg::BCD_W-1 -: 4];
  assign keep    = (mode == itaf_pkg::MODE_USD) ? itaf_pkg::KEEP_USD : itaf_pkg::KEEP_STD;
  assign raw     = item.value;

  itaf_bcd_conv u_conv (
    .clk    (clk),
    .load   (accept),
    .step   (state == itaf_pkg::S_CONV),
    .bin_in (raw[31] ? (~raw + 32'd1) : raw),
    .bcd    (bcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itaf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_char  = itaf_pkg::CH_ZERO;
    emit_last  = 1'b0;
    unique case (state)
      itaf_pkg::S_IDLE: begin
        if (accept) begin
          if (item.mode == itaf_pkg::MODE_DEC || item.mode == itaf_pkg::MODE_USD) begin
            state_next = itaf_pkg::S_CONV;
          end else begin
            state_next = itaf_pkg::S_LOAD;
          end
        end
      end
      itaf_pkg::S_CONV: begin
        if (cnt == 5'd0) begin
          state_next = itaf_pkg::S_LOAD;
        end
      end
      itaf_pkg::S_LOAD: begin
        state_next = neg ? itaf_pkg::S_SIGN : itaf_pkg::S_LEAD;
      end
      itaf_pkg::S_SIGN: begin
        emit       = 1'b1;
        emit_char  = itaf_pkg::CH_MINUS;
        state_next = itaf_pkg::S_LEAD;
      end
      itaf_pkg::S_LEAD: begin
        unique case (mode)
          itaf_pkg::MODE_DEC: begin
            state_next = itaf_pkg::S_SKIP;
          end
          itaf_pkg::MODE_USD: begin
            emit       = 1'b1;
            emit_char  = itaf_pkg::CH_DOLLAR;
            state_next = itaf_pkg::S_SKIP;
          end
          default: begin
            emit       = 1'b1;
            emit_char  = itaf_pkg::CH_ZERO;
            state_next = itaf_pkg::S_PFX;
          end
        endcase
      end
      itaf_pkg::S_PFX: begin
        emit       = 1'b1;
        emit_char  = is_bin ? itaf_pkg::CH_B : itaf_pkg::CH_X;
        state_next = itaf_pkg::S_SKIP;
      end
      itaf_pkg::S_SKIP: begin
        if (!(top_dig == 4'd0 && ndig > keep)) begin
          state_next = itaf_pkg::S_DIGIT;
        end
      end
      itaf_pkg::S_DIGIT: begin
        emit      = 1'b1;
        emit_char = itaf_pkg::digit_char(top_dig);
        emit_last = (ndig == itaf_pkg::CNT_W'(1));
        if (ndig == itaf_pkg::CNT_W'(1)) begin
          state_next = itaf_pkg::S_IDLE;
        end else if (mode == itaf_pkg::MODE_USD && ndig == itaf_pkg::KEEP_USD) begin
          state_next = itaf_pkg::S_DOT;
        end
      end
      itaf_pkg::S_DOT: begin
        emit       = 1'b1;
        emit_char  = itaf_pkg::CH_DOT;
        state_next = itaf_pkg::S_DIGIT;
      end
      default: begin
        state_next = itaf_pkg::S_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode <= item.mode;
      neg  <= raw[31];
      mag  <= raw[31] ? (~raw + 32'd1) : raw;
      cnt  <= 5'd31;
    end else if (state == itaf_pkg::S_CONV) begin
      cnt <= cnt - 5'd1;
    end

    if (state == itaf_pkg::S_LOAD) begin
      unique case (mode)
        itaf_pkg::MODE_BIN: begin
          digits <= {mag, 8'h00};
          ndig   <= itaf_pkg::NDIG_BIN;
        end
        itaf_pkg::MODE_HEX: begin
          digits <= {mag, 8'h00};
          ndig   <= itaf_pkg::NDIG_HEX;
        end
        default: begin
          digits <= bcd;
          ndig   <= itaf_pkg::NDIG_DEC;
        end
      endcase
    end else if ((state == itaf_pkg::S_SKIP && top_dig == 4'd0 && ndig > keep)
                 || state == itaf_pkg::S_DIGIT) begin
      digits <= is_bin ? {digits[itaf_pkg::BCD_W-2:0], 1'b0}
                       : {digits[itaf_pkg::BCD_W-5:0], 4'h0};
      ndig   <= ndig - itaf_pkg::CNT_W'(1);
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    result.text_char <= emit_char;
    result.last_char <= emit_last;
  end

`ifndef ASSERT_OFF
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) != itaf_pkg::S_IDLE)
    else $error("character sent without an item in progress");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last_char) |-> state == itaf_pkg::S_IDLE)
    else $error("last character sent while sequencer still active");

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    (state == itaf_pkg::S_DIGIT || state == itaf_pkg::S_DOT) |-> ndig != '0)
    else $error("digit state entered with no digits left");

  a_dot_place: assert property (@(posedge clk) disable iff (rst)
    (state == itaf_pkg::S_DOT) |-> (mode == itaf_pkg::MODE_USD &&
                                   ndig == itaf_pkg::CNT_W'(2)))
    else $error("decimal point out of place");
`endif

endmodule
